// ----- hw/rtl/pseg_pkg.sv -----
// Package for the packet segmenter: widths, register indexes, status codes
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pseg_pkg;

  localparam int unsigned MaxSegments = 64;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned LenW   = 16;  // payload, length and offset
  localparam int unsigned AddrW  = 8;   // address field lengths
  localparam int unsigned SeqW   = 32;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned QuotW  = 7;   // segment count, also the quotient
  localparam int unsigned StepW  = 3;   // counts the quotient bits
  localparam int unsigned RoomW  = 15;  // half of the message limit
  localparam int unsigned HdrW   = 10;  // sum of three byte-wide lengths
  localparam int unsigned ProdW  = RoomW + QuotW;

  localparam logic [LenW-1:0]  LimitRst = 16'd1024;
  localparam logic [AddrW-1:0] HdrRst   = 8'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMessageLimit = 4'd0,
    CfgFixedHeader  = 4'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoRoom  = 2'd1,
    StTooMany = 2'd2
  } status_e;

  typedef struct packed {
    logic [LenW-1:0]  payload_length;
    logic [AddrW-1:0] source_length;
    logic [AddrW-1:0] dest_length;
    logic             originating;
    logic [SeqW-1:0]  forward_seq;
  } pkt_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    room;
    logic    mul;
    logic    div_init;
    logic    div_step;
    logic    fin;
    logic    emit_seg;
    logic    emit_err;
    status_e err_code;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic no_room;
    logic too_many;
    logic div_last;
    logic seg_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pseg_intf.sv -----
// Handshake channels of the packet segmenter: packet requests, segment
// requests and register writes. Depends on pseg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pseg_pkt_if;
  logic                            valid;
  logic                            ready;
  logic [pseg_pkg::LenW-1:0]       payload_length;
  logic [pseg_pkg::AddrW-1:0]      source_length;
  logic [pseg_pkg::AddrW-1:0]      dest_length;
  logic                            originating;
  logic [pseg_pkg::SeqW-1:0]       forward_seq;

  modport source (output valid, payload_length, source_length, dest_length,
                  originating, forward_seq, input ready);
  modport sink   (input valid, payload_length, source_length, dest_length,
                  originating, forward_seq, output ready);
endinterface

interface pseg_seg_if;
  logic                            valid;
  logic                            ready;
  logic [pseg_pkg::SeqW-1:0]       seq_out;
  logic [pseg_pkg::IdxW-1:0]       seg_index;
  logic [pseg_pkg::QuotW-1:0]      seg_count;
  logic [pseg_pkg::LenW-1:0]       seg_length;
  logic [pseg_pkg::LenW-1:0]       seg_offset;
  logic                            own_source;
  logic                            last;
  logic [1:0]                      status;

  modport source (output valid, seq_out, seg_index, seg_count, seg_length,
                  seg_offset, own_source, last, status, input ready);
  modport sink   (input valid, seq_out, seg_index, seg_count, seg_length,
                  seg_offset, own_source, last, status, output ready);
endinterface

interface pseg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pseg_pkg::CfgIdxW-1:0]    index;
  logic [pseg_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/packet_segmenter_top.sv -----
// Top level of the packet segmenter: joins the controller and the datapath
// and checks their cooperation. Depends on pseg_pkg, pseg_intf, pseg_ctrl, pseg_dp.
`timescale 1ns / 1ps
`default_nettype none

// The segmenter takes one packet request and returns one segment request per
// segment, or a single error request when the header leaves no payload room
// (status 1) or the packet needs more than MAX_SEGMENTS segments (status 2).
// Segment room is half the message limit less the fixed header and both
// address lengths; every segment but the last carries the full room. An
// originated packet takes the internal sequence counter, which then advances,
// even on error; a forwarded packet keeps its own number. One packet at a time
// is worked on: after acceptance the Room, Mul and Check states make the room
// and limit checks, the bit-per-cycle restoring divider yields the segment
// count, Fin sets up the walk, then Emit sends one segment per cycle while
// the output is free (an error leaves Check for Err instead). The output
// register lets the next packet be accepted while the final request of the
// previous one still waits. Register writes are taken at any time and should
// only be issued while the block is idle.
module packet_segmenter_top #(
  parameter int unsigned MAX_SEGMENTS = pseg_pkg::MaxSegments
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pseg_pkt_if.sink   pkt_i,
  pseg_seg_if.source seg_o,
  pseg_cfg_if.sink   cfg_i
);

  pseg_pkg::cmd_t  cmd;
  pseg_pkg::stat_t stat;
  pseg_pkg::pkt_t  pkt;
  logic            in_ready;

  // Gather the packet fields for the datapath
  assign pkt.payload_length = pkt_i.payload_length;
  assign pkt.source_length  = pkt_i.source_length;
  assign pkt.dest_length    = pkt_i.dest_length;
  assign pkt.originating    = pkt_i.originating;
  assign pkt.forward_seq    = pkt_i.forward_seq;
  assign pkt_i.ready        = in_ready;

  pseg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pkt_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pseg_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pkt_i  (pkt),
    .cmd_i  (cmd),
    .stat_o (stat),
    .cfg_i  (cfg_i),
    .seg_o  (seg_o)
  );

  // Hold off further packets once one is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_i.valid && pkt_i.ready) |=> !pkt_i.ready)
    else $error("packet accepted while previous still in work");

  // Never load a segment and an error result together
  a_single_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.emit_seg && cmd.emit_err))
    else $error("segment and error emitted together");

  // An emitted result shows on the output next cycle
  a_emit_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_seg || cmd.emit_err) |=> seg_o.valid)
    else $error("emitted result not presented");

  // Error results close the packet and carry no count
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_o.valid && seg_o.status != pseg_pkg::StOk)
      |-> (seg_o.last && seg_o.seg_count == '0))
    else $error("malformed error result");

endmodule

`default_nettype wire

// ----- hw/rtl/pseg_ctrl.sv -----
// Sequencing state machine of the packet segmenter: steps the datapath
// through room check, limit check, division and emission. Depends on pseg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pseg_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire pseg_pkg::stat_t stat_i,
  output pseg_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    Idle, Room, Mul, Check, Div, Fin, Emit, Err
  } state_e;

  state_e            state_q;
  logic              in_ready_q;
  pseg_pkg::status_e err_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.err_code = err_q;
    cmd_o.load     = in_ready_q & in_valid_i;
    case (state_q)
      Room:    cmd_o.room     = 1'b1;
      Mul:     cmd_o.mul      = 1'b1;
      Check:   cmd_o.div_init = 1'b1;
      Div:     cmd_o.div_step = 1'b1;
      Fin:     cmd_o.fin      = 1'b1;
      Emit:    cmd_o.emit_seg = stat_i.out_free;
      Err:     cmd_o.emit_err = stat_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= Idle;
      in_ready_q <= 1'b1;
      err_q      <= pseg_pkg::StOk;
    end else begin
      case (state_q)
        Idle: begin
          if (in_ready_q && in_valid_i) begin
            state_q    <= Room;
            in_ready_q <= 1'b0;
          end
        end
        Room:  state_q <= Mul;
        Mul:   state_q <= Check;
        Check: begin
          if (stat_i.no_room) begin
            err_q   <= pseg_pkg::StNoRoom;
            state_q <= Err;
          end else if (stat_i.too_many) begin
            err_q   <= pseg_pkg::StTooMany;
            state_q <= Err;
          end else begin
            state_q <= Div;
          end
        end
        Div: begin
          if (stat_i.div_last) state_q <= Fin;
        end
        Fin:   state_q <= Emit;
        Emit: begin
          if (stat_i.out_free && stat_i.seg_last) begin
            state_q    <= Idle;
            in_ready_q <= 1'b1;
          end
        end
        Err: begin
          if (stat_i.out_free) begin
            state_q    <= Idle;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= Idle;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pseg_dp.sv -----
// Datapath of the packet segmenter: registers, sequence counter, restoring
// divider, segment walk and output register. Depends on pseg_pkg, pseg_intf.
`timescale 1ns / 1ps
`default_nettype none

module pseg_dp #(
  parameter int unsigned MAX_SEGMENTS = pseg_pkg::MaxSegments
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pseg_pkg::pkt_t  pkt_i,
  input  wire pseg_pkg::cmd_t  cmd_i,
  output pseg_pkg::stat_t      stat_o,
  pseg_cfg_if.sink             cfg_i,
  pseg_seg_if.source           seg_o
);

  localparam int unsigned LenW  = pseg_pkg::LenW;
  localparam int unsigned RoomW = pseg_pkg::RoomW;
  localparam int unsigned HdrW  = pseg_pkg::HdrW;
  localparam int unsigned ProdW = pseg_pkg::ProdW;
  localparam int unsigned QuotW = pseg_pkg::QuotW;
  localparam int unsigned StepW = pseg_pkg::StepW;
  localparam int unsigned IdxW  = pseg_pkg::IdxW;
  localparam int unsigned SeqW  = pseg_pkg::SeqW;

  logic [LenW-1:0]            limit_q;
  logic [pseg_pkg::AddrW-1:0] fhb_q;
  logic [SeqW-1:0]            seq_cnt_q;

  logic [LenW-1:0]  payload_q;
  logic [HdrW-1:0]  hdr_q;
  logic [RoomW-1:0] half_q;
  logic             orig_q;
  logic [SeqW-1:0]  seq_q;
  logic [RoomW-1:0] room_q;
  logic             no_room_q;
  logic [ProdW-1:0] prod_q;
  logic [LenW-1:0]  rem_q;
  logic [QuotW-1:0] quot_q;
  logic [StepW-1:0] step_q;
  logic [QuotW-1:0] count_q;
  logic [IdxW-1:0]  idx_q;
  logic [LenW-1:0]  off_q;
  logic [LenW-1:0]  left_q;

  logic             out_valid_q;
  logic [SeqW-1:0]  o_seq_q;
  logic [IdxW-1:0]  o_idx_q;
  logic [QuotW-1:0] o_cnt_q;
  logic [LenW-1:0]  o_len_q;
  logic [LenW-1:0]  o_off_q;
  logic             o_own_q;
  logic             o_last_q;
  logic [1:0]       o_status_q;

  logic [ProdW-1:0] trial;
  logic             fits;
  logic             seg_last;
  logic [LenW-1:0]  room_ext;

  assign room_ext = LenW'(room_q);
  assign trial    = ProdW'(room_q) << step_q;
  assign fits     = ProdW'(rem_q) >= trial;
  assign seg_last = (QuotW'(idx_q) + QuotW'(1)) == count_q;

  assign stat_o.no_room  = no_room_q;
  assign stat_o.too_many = ProdW'(payload_q) > prod_q;
  assign stat_o.div_last = step_q == '0;
  assign stat_o.seg_last = seg_last;
  assign stat_o.out_free = !out_valid_q || seg_o.ready;

  assign cfg_i.ready = 1'b1;

  // Registers and sequence counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= pseg_pkg::LimitRst;
      fhb_q     <= pseg_pkg::HdrRst;
      seq_cnt_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          pseg_pkg::CfgMessageLimit: limit_q <= cfg_i.data;
          pseg_pkg::CfgFixedHeader:  fhb_q   <= cfg_i.data[pseg_pkg::AddrW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load && pkt_i.originating) seq_cnt_q <= seq_cnt_q + SeqW'(1);
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      payload_q <= pkt_i.payload_length;
      hdr_q     <= HdrW'(fhb_q) + HdrW'(pkt_i.source_length)
                 + HdrW'(pkt_i.dest_length);
      half_q    <= limit_q[LenW-1:1];
      orig_q    <= pkt_i.originating;
      seq_q     <= pkt_i.originating ? seq_cnt_q : pkt_i.forward_seq;
    end
    if (cmd_i.room) begin
      no_room_q <= RoomW'(hdr_q) >= half_q;
      room_q    <= half_q - RoomW'(hdr_q);
    end
    if (cmd_i.mul) prod_q <= ProdW'(room_q) * ProdW'(MAX_SEGMENTS);
    if (cmd_i.div_init) begin
      rem_q  <= payload_q;
      quot_q <= '0;
      step_q <= StepW'(QuotW - 1);
    end
    if (cmd_i.div_step) begin
      if (fits) begin
        rem_q          <= rem_q - trial[LenW-1:0];
        quot_q[step_q] <= 1'b1;
      end
      step_q <= step_q - StepW'(1);
    end
    if (cmd_i.fin) begin
      count_q <= (payload_q == '0) ? QuotW'(1)
                                    : quot_q + QuotW'(rem_q != '0);
      idx_q   <= '0;
      off_q   <= '0;
      left_q  <= payload_q;
    end
    if (cmd_i.emit_seg) begin
      idx_q  <= idx_q + IdxW'(1);
      off_q  <= off_q + room_ext;
      left_q <= left_q - room_ext;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_seg || cmd_i.emit_err) begin
      out_valid_q <= 1'b1;
    end else if (seg_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_seg) begin
      o_seq_q    <= seq_q;
      o_idx_q    <= idx_q;
      o_cnt_q    <= count_q;
      o_len_q    <= seg_last ? left_q : room_ext;
      o_off_q    <= off_q;
      o_own_q    <= orig_q;
      o_last_q   <= seg_last;
      o_status_q <= pseg_pkg::StOk;
    end else if (cmd_i.emit_err) begin
      o_seq_q    <= seq_q;
      o_idx_q    <= '0;
      o_cnt_q    <= '0;
      o_len_q    <= '0;
      o_off_q    <= '0;
      o_own_q    <= orig_q;
      o_last_q   <= 1'b1;
      o_status_q <= cmd_i.err_code;
    end
  end

  assign seg_o.valid      = out_valid_q;
  assign seg_o.seq_out    = o_seq_q;
  assign seg_o.seg_index  = o_idx_q;
  assign seg_o.seg_count  = o_cnt_q;
  assign seg_o.seg_length = o_len_q;
  assign seg_o.seg_offset = o_off_q;
  assign seg_o.own_source = o_own_q;
  assign seg_o.last       = o_last_q;
  assign seg_o.status     = o_status_q;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for packet_segmenter_top. It drives packet requests and
// register writes, predicts every segment request and checks them in order.
// Depends on pseg_pkg, the pseg_intf channels and the segmenter RTL.

module testbench;
  import pseg_pkg::*;

  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned ResetCycles = 11;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned HalfDivisor = 2;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned PhaseItems  = 64;
  localparam int unsigned HoldCycles  = 400;

  // Indexes that decode to no register: writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] CfgSpareLow  = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHigh = 4'd15;

  // One segment request as it leaves the block.
  typedef struct packed {
    logic [SeqW-1:0]  seq;
    logic [IdxW-1:0]  idx;
    logic [QuotW-1:0] count;
    logic [LenW-1:0]  len;
    logic [LenW-1:0]  off;
    logic             own;
    logic             last;
    status_e          status;
  } seg_t;

  // Predicts the segment requests of each accepted packet request and checks
  // the returned ones against them in arrival order.
  class segment_scoreboard;
    logic [LenW-1:0]  limit;
    logic [AddrW-1:0] hdr_bytes;
    logic [SeqW-1:0]  next_seq;
    seg_t             expected_segs[$];
    int unsigned      mismatches;
    int unsigned      reported;

    function new();
      limit      = LimitRst;
      hdr_bytes  = HdrRst;
      next_seq   = '0;
      mismatches = 0;
      reported   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgMessageLimit: limit = data;
        CfgFixedHeader:  hdr_bytes = data[AddrW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_segs.size();
    endfunction

    function string show(seg_t s);
      return $sformatf("seq=%08h idx=%0d cnt=%0d len=%0d off=%0d own=%0b last=%0b st=%0d",
                       s.seq, s.idx, s.count, s.len, s.off, s.own, s.last, s.status);
    endfunction

    function void note_packet(pkt_t p);
      seg_t        s;
      int unsigned half, header, room, count, i;
      s      = '0;
      s.seq  = p.originating ? next_seq : p.forward_seq;
      s.own  = p.originating;
      s.last = 1'b1;
      // The counter advances for every originated packet, errors included.
      if (p.originating) next_seq = next_seq + SeqW'(1);
      half   = limit / HalfDivisor;
      header = hdr_bytes + p.source_length + p.dest_length;
      if (header >= half) begin
        s.status = StNoRoom;
        expected_segs.push_back(s);
        return;
      end
      room  = half - header;
      count = (p.payload_length < room) ? 1 : (p.payload_length + room - 1) / room;
      if (count > MaxSegments) begin
        s.status = StTooMany;
        expected_segs.push_back(s);
        return;
      end
      s.status = StOk;
      s.count  = QuotW'(count);
      for (i = 0; i < count; i++) begin
        s.idx  = IdxW'(i);
        s.off  = LenW'(i * room);
        s.len  = (i == count - 1) ? LenW'(p.payload_length - room * (count - 1))
                                  : LenW'(room);
        s.last = (i == count - 1);
        expected_segs.push_back(s);
      end
    endfunction

    function void check_segment(seg_t got);
      seg_t want;
      if (expected_segs.size() == 0) begin
        mismatches++;
        if (reported < MaxReports) begin
          reported++;
          $display("[%0t] unexpected segment request: %s", $realtime, show(got));
        end
        return;
      end
      want = expected_segs.pop_front();
      if (got !== want) begin
        mismatches++;
        if (reported < MaxReports) begin
          reported++;
          $display("[%0t] segment request mismatch", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function bit clean();
      if (expected_segs.size() != 0) begin
        mismatches++;
        $display("%0d segment requests never arrived", expected_segs.size());
      end
      return mismatches == 0;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pseg_pkt_if pkt_if ();
  pseg_seg_if seg_if ();
  pseg_cfg_if cfg_if ();

  segment_scoreboard sb = new();

  // Set by the stimulus: drop all idling on both sides, or hold the segment
  // channel off for a long stretch.
  bit          no_idle   = 1'b0;
  int unsigned sink_hold = 0;

  packet_segmenter_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pkt_i  (pkt_if),
    .seg_o  (seg_if),
    .cfg_i  (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Give up on a hung run.
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", CycleLimit);
    $display("packet_segmenter_top verification failed");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  // Segment channel receiver: drive ready at the falling edge, idle a random
  // number of cycles before each request, and honour a long hold-off when
  // one is asked for.
  initial begin : segment_sink
    int unsigned pause;
    seg_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold != 0) begin
        seg_if.ready = 1'b0;
        repeat (sink_hold) @(negedge clk_i);
        sink_hold = 0;
      end
      pause = draw_gap();
      if (pause != 0) begin
        seg_if.ready = 1'b0;
        repeat (pause) @(negedge clk_i);
      end
      seg_if.ready = 1'b1;
      do @(posedge clk_i); while (seg_if.valid !== 1'b1);
    end
  end

  // Sample every accepted segment request at the rising edge.
  always @(posedge clk_i) begin : segment_monitor
    seg_t got;
    if (rst_ni === 1'b1 && seg_if.valid === 1'b1 && seg_if.ready === 1'b1) begin
      got.seq    = seg_if.seq_out;
      got.idx    = seg_if.seg_index;
      got.count  = seg_if.seg_count;
      got.len    = seg_if.seg_length;
      got.off    = seg_if.seg_offset;
      got.own    = seg_if.own_source;
      got.last   = seg_if.last;
      got.status = status_e'(seg_if.status);
      sb.check_segment(got);
    end
  end

  // Drop the packet offer, then hold until every predicted segment request
  // has come back.
  task automatic wait_idle();
    pkt_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Write one register; called at a falling edge, returns at one.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Offer one packet request after a random gap and note it once accepted.
  // Valid stays high into the next request when that one has no gap.
  task automatic send_pkt(input pkt_t p);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      pkt_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pkt_if.valid          = 1'b1;
    pkt_if.payload_length = p.payload_length;
    pkt_if.source_length  = p.source_length;
    pkt_if.dest_length    = p.dest_length;
    pkt_if.originating    = p.originating;
    pkt_if.forward_seq    = p.forward_seq;
    do @(posedge clk_i); while (pkt_if.ready !== 1'b1);
    sb.note_packet(p);
    @(negedge clk_i);
  endtask

  function automatic pkt_t make_pkt(logic [LenW-1:0] payload, logic [AddrW-1:0] src,
                                    logic [AddrW-1:0] dst, logic orig, logic [SeqW-1:0] fwd);
    pkt_t p;
    p.payload_length = payload;
    p.source_length  = src;
    p.dest_length    = dst;
    p.originating    = orig;
    p.forward_seq    = fwd;
    return p;
  endfunction

  // Mostly well-formed packets sized to land on a chosen segment count under
  // the current settings, some sized past the segment limit, and the rest
  // fully random fields (which also reach the no-room case).
  function automatic pkt_t random_pkt();
    pkt_t        p;
    int unsigned half, avail, room, segs, lo, hi, pick;
    p = make_pkt(16'($urandom()), 8'($urandom()), 8'($urandom()),
                 1'($urandom_range(0, 1)), $urandom());
    half = sb.limit / HalfDivisor;
    pick = $urandom_range(0, 99);
    if (half > sb.hdr_bytes && pick < 85) begin
      // Keep the header below half the limit so that some room is left.
      avail           = half - sb.hdr_bytes - 1;
      p.source_length = 8'($urandom_range(0, (avail > 255) ? 255 : avail));
      avail           = avail - p.source_length;
      p.dest_length   = 8'($urandom_range(0, (avail > 255) ? 255 : avail));
      room = half - sb.hdr_bytes - p.source_length - p.dest_length;
      if (pick < 72)
        segs = ($urandom_range(0, 15) == 0) ? $urandom_range(1, MaxSegments)
                                            : $urandom_range(1, 6);
      else
        segs = $urandom_range(MaxSegments + 1, MaxSegments + 16);
      lo = (segs - 1) * room;
      hi = segs * room;
      // A count the payload width cannot reach leaves the random payload.
      if (lo < 65535)
        p.payload_length = 16'($urandom_range((segs == 1) ? 0 : lo + 1,
                                              (hi > 65535) ? 65535 : hi));
    end
    return p;
  endfunction

  initial begin : stimulus
    logic [LenW-1:0]     lim;
    logic [AddrW-1:0]    hdr;
    logic [CfgDataW-1:0] junk;
    int unsigned         n_items;

    rst_ni                = 1'b0;
    pkt_if.valid          = 1'b0;
    pkt_if.payload_length = '0;
    pkt_if.source_length  = '0;
    pkt_if.dest_length    = '0;
    pkt_if.originating    = 1'b0;
    pkt_if.forward_seq    = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = CfgMessageLimit;
    cfg_if.data           = '0;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed requests under the reset settings: half limit 512, header 16,
    // so with empty address fields the room is 496 bytes.
    send_pkt(make_pkt(16'd0, 8'd0, 8'd0, 1'b1, 32'h0));            // empty payload
    send_pkt(make_pkt(16'd495, 8'd0, 8'd0, 1'b1, 32'h0));          // just below room
    send_pkt(make_pkt(16'd496, 8'd0, 8'd0, 1'b1, 32'h0));          // exactly room
    send_pkt(make_pkt(16'd497, 8'd0, 8'd0, 1'b0, 32'h1234_5678));  // spills over
    send_pkt(make_pkt(16'd31744, 8'd0, 8'd0, 1'b1, 32'h0));        // most segments
    send_pkt(make_pkt(16'd31745, 8'd0, 8'd0, 1'b1, 32'h0));        // one too many
    send_pkt(make_pkt(16'hFFFF, 8'd0, 8'd0, 1'b0, 32'hFFFF_FFFF)); // far too many
    send_pkt(make_pkt(16'd10, 8'd248, 8'd248, 1'b1, 32'h0));       // header equals half
    send_pkt(make_pkt(16'hFFFF, 8'hFF, 8'hFF, 1'b0, 32'h0));       // widest header
    send_pkt(make_pkt(16'd64, 8'd247, 8'd248, 1'b1, 32'h0));       // one-byte room
    send_pkt(make_pkt(16'd65, 8'd247, 8'd248, 1'b0, 32'h8000_0000));
    send_pkt(make_pkt(16'd1000, 8'd10, 8'd20, 1'b0, 32'h8000_0001));
    send_pkt(make_pkt(16'd1, 8'd0, 8'd0, 1'b0, 32'h0));

    // Random phases, each under its own settings: the extremes of both
    // registers, a limit below its range and a return to the reset values.
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      n_items = PhaseItems;
      case (ph)
        0: begin lim = 16'd16;    hdr = 8'd0;   end
        1: begin lim = 16'hFFFF;  hdr = 8'hFF;  end
        2: begin lim = 16'hFFFF;  hdr = 8'd0;   end
        3: begin lim = 16'd3;     hdr = 8'd0;   n_items = 20; end
        4: begin lim = 16'd300;   hdr = 8'd40;  end
        5: begin lim = 16'd2000;  hdr = 8'd100; end
        default: begin lim = LimitRst; hdr = HdrRst; end
      endcase
      junk = $urandom();
      write_reg(CfgMessageLimit, lim);
      write_reg(CfgFixedHeader, {junk[CfgDataW-1:AddrW], hdr});
      // A write to an unused index must leave both registers alone.
      write_reg(ph[0] ? CfgSpareLow : CfgSpareHigh, 16'($urandom()));
      no_idle = (ph == 2 || ph == 5);

      for (int n = 0; n < n_items; n++) begin
        // Starve the output for a while and keep offering requests, so the
        // block fills up and must stall its input.
        if (ph == 1 && n == 8) sink_hold = HoldCycles;
        // Pause mid-phase until every outstanding segment request is back.
        if (n == n_items / 2) wait_idle();
        send_pkt(random_pkt());
      end
    end
    pkt_if.valid = 1'b0;
    no_idle      = 1'b0;

    // Drain, then watch a while longer for stray segment requests.
    wait_idle();
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.clean())
      $display("packet_segmenter_top verification clean");
    else
      $display("packet_segmenter_top verification failed");
    $finish;
  end

endmodule

// ----- packet_segmenter_top.f -----
hw/rtl/pseg_pkg.sv
hw/rtl/pseg_intf.sv
hw/rtl/pseg_ctrl.sv
hw/rtl/pseg_dp.sv
hw/rtl/packet_segmenter_top.sv
tb/testbench.sv
